[sv/tpbd_pkg.sv]
`default_nettype none

package tpbd_pkg;

  typedef enum logic [3:0] {
    KIND_SAMPLE     = 4'd0,
    KIND_SILENCE    = 4'd1,
    KIND_NOTE       = 4'd2,
    KIND_ENV_OFF    = 4'd3,
    KIND_ENV_SET    = 4'd4,
    KIND_ROW_END    = 4'd5,
    KIND_ORNAMENT   = 4'd6,
    KIND_PERIOD     = 4'd7,
    KIND_VOLUME     = 4'd8,
    KIND_TEMPO      = 4'd9,
    KIND_GLIDE      = 4'd10,
    KIND_GLIDE_NOTE = 4'd11,
    KIND_GLIDE_OFF  = 4'd12,
    KIND_NOISE_ADD  = 4'd13,
    KIND_TRUNCATED  = 4'd14
  } kind_t;

  localparam logic [7:0] SAMPLE_FIRST  = 8'hE1;
  localparam logic [7:0] SILENCE_CODE  = 8'hE0;
  localparam logic [7:0] NOTE_FIRST    = 8'h80;
  localparam logic [7:0] NOTE_LAST     = 8'hDF;
  localparam logic [7:0] ENV_OFF_CODE  = 8'h7F;
  localparam logic [7:0] ENV_SET_FIRST = 8'h71;
  localparam logic [7:0] ENV_SET_LAST  = 8'h7E;
  localparam logic [7:0] ROW_END_CODE  = 8'h70;
  localparam logic [7:0] ORN_FIRST     = 8'h60;
  localparam logic [7:0] PERIOD_FIRST  = 8'h20;
  localparam logic [7:0] VOLUME_FIRST  = 8'h10;
  localparam logic [7:0] TEMPO_CODE    = 8'h0F;
  localparam logic [7:0] GLIDE_CODE    = 8'h0E;
  localparam logic [7:0] GNOTE_CODE    = 8'h0D;
  localparam logic [7:0] GLIDE_OFF_CODE = 8'h0C;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       is_last;
  } in_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        amount;
    logic signed [7:0] delta;
    logic [15:0]       env_period;
    logic              row_done;
  } out_t;

endpackage

`default_nettype wire

[sv/tracker_pattern_byte_decoder_unit.sv]
// tracker pattern byte decoder
// in channel: one pattern byte per transaction (byte_in, is_last) on in_valid/in_stall.
// out channel: one decoded command per transaction on out_valid/out_stall.
// a command byte without operands puts its result into the result queue when it is
// taken; a command with operands does so when its last operand is taken.
// is_last before all operands arrive gives a truncated result and returns to idle.
// throughput is one byte per cycle while in_stall is low: decode and operand
// gathering are a single level of logic ahead of a two-entry result queue.
// the queue lets a byte be taken while a finished result waits; in_stall rises only
// when both queue entries are full, so a stalled receiver holds the sender back after
// at most two waiting results.
// rst (synchronous) empties the queue and clears the operand state, so the next
// byte is decoded as a command byte.
`default_nettype none

module tracker_pattern_byte_decoder_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire tpbd_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output tpbd_pkg::out_t    out_data
);
  import tpbd_pkg::*;

  logic [1:0] bytes_pending, bytes_pending_next;
  kind_t      pending_kind, pending_kind_next;
  logic [3:0] held_shape, held_shape_next;
  logic [7:0] held_low_byte, held_low_byte_next;
  logic [7:0] held_delta, held_delta_next;

  out_t       res;
  logic       res_valid;
  out_t       slot0, slot1;
  logic [1:0] count;
  logic       accept, push, pop;
  logic [7:0] b;
  logic       last;
  logic [1:0] dec;

  assign b    = in_data.byte_in;
  assign last = in_data.is_last;
  assign dec  = bytes_pending - 2'd1;

  always_comb begin
    bytes_pending_next = bytes_pending;
    pending_kind_next  = pending_kind;
    held_shape_next    = held_shape;
    held_low_byte_next = held_low_byte;
    held_delta_next    = held_delta;
    res                = '0;
    res_valid          = 1'b0;
    if (bytes_pending != 2'd0) begin
      bytes_pending_next = dec;
      if (bytes_pending == 2'd3) begin
        held_delta_next = b;
      end else if (bytes_pending == 2'd2 && pending_kind == KIND_ENV_SET) begin
        held_low_byte_next = b;
      end
      if (dec == 2'd0) begin
        res_valid = 1'b1;
        res.kind  = pending_kind;
        unique case (pending_kind)
          KIND_ENV_SET: begin
            res.amount     = {4'd0, held_shape};
            res.env_period = {b, held_low_byte};
          end
          KIND_TEMPO: begin
            res.amount = b;
          end
          KIND_GLIDE, KIND_NOISE_ADD: begin
            res.delta = b;
          end
          KIND_GLIDE_NOTE: begin
            res.delta = held_delta;
          end
          default: begin
          end
        endcase
      end else if (last) begin
        bytes_pending_next = 2'd0;
        res_valid          = 1'b1;
        res.kind           = KIND_TRUNCATED;
      end
    end else begin
      res_valid = 1'b1;
      priority if (b >= SAMPLE_FIRST) begin
        res.kind   = KIND_SAMPLE;
        res.amount = b - SILENCE_CODE;
      end else if (b == SILENCE_CODE) begin
        res.kind     = KIND_SILENCE;
        res.row_done = 1'b1;
      end else if (b >= NOTE_FIRST && b <= NOTE_LAST) begin
        res.kind     = KIND_NOTE;
        res.amount   = b - NOTE_FIRST;
        res.row_done = 1'b1;
      end else if (b == ENV_OFF_CODE) begin
        res.kind = KIND_ENV_OFF;
      end else if (b >= ENV_SET_FIRST && b <= ENV_SET_LAST) begin
        held_shape_next = b[3:0];
        if (last) begin
          res.kind = KIND_TRUNCATED;
        end else begin
          res_valid          = 1'b0;
          bytes_pending_next = 2'd2;
          pending_kind_next  = KIND_ENV_SET;
        end
      end else if (b == ROW_END_CODE) begin
        res.kind     = KIND_ROW_END;
        res.row_done = 1'b1;
      end else if (b >= ORN_FIRST) begin
        res.kind   = KIND_ORNAMENT;
        res.amount = b - ORN_FIRST;
      end else if (b >= PERIOD_FIRST) begin
        res.kind   = KIND_PERIOD;
        res.amount = b - PERIOD_FIRST;
      end else if (b >= VOLUME_FIRST) begin
        res.kind   = KIND_VOLUME;
        res.amount = b - VOLUME_FIRST;
      end else if (b == GLIDE_OFF_CODE) begin
        res.kind = KIND_GLIDE_OFF;
      end else begin
        if (last) begin
          res.kind = KIND_TRUNCATED;
        end else begin
          res_valid = 1'b0;
          if (b == TEMPO_CODE) begin
            bytes_pending_next = 2'd1;
            pending_kind_next  = KIND_TEMPO;
          end else if (b == GLIDE_CODE) begin
            bytes_pending_next = 2'd1;
            pending_kind_next  = KIND_GLIDE;
          end else if (b == GNOTE_CODE) begin
            bytes_pending_next = 2'd3;
            pending_kind_next  = KIND_GLIDE_NOTE;
          end else begin
            bytes_pending_next = 2'd1;
            pending_kind_next  = KIND_NOISE_ADD;
          end
        end
      end
    end
  end

  assign in_stall  = (count == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign push      = accept && res_valid;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      pending_kind  <= KIND_SAMPLE;
      held_shape    <= 4'd0;
      held_low_byte <= 8'd0;
      held_delta    <= 8'd0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      pending_kind  <= pending_kind_next;
      held_shape    <= held_shape_next;
      held_low_byte <= held_low_byte_next;
      held_delta    <= held_delta_next;
    end
  end

  // two-entry result queue, head in slot0
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        slot0 <= res;
      end else begin
        slot0 <= slot1;
      end
      if (push && count == 2'd2) begin
        slot1 <= res;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end
  end

endmodule

`default_nettype wire

[test/tb_tracker_pattern_byte_decoder_unit.sv]
`default_nettype none

module tb_tracker_pattern_byte_decoder_unit;
  import tpbd_pkg::*;

  localparam int RANDOM_BYTES = 950;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  tracker_pattern_byte_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  in_t  byte_queue[$];
  out_t expected_cmds[$];
  int   errors = 0;
  int   cycles = 0;
  int   in_gap = 0;
  int   stall_left = 0;
  logic in_taken = 1'b0;
  logic quiet = 1'b0;

  // operand gathering state of the decoder
  logic [1:0] opnd_left = '0;
  kind_t      held_kind = KIND_SAMPLE;
  logic [3:0] env_shape = '0;
  logic [7:0] env_lo = '0;
  logic [7:0] gn_delta = '0;

  function automatic logic hold_cmd(kind_t k, logic [1:0] n, logic last, output out_t res);
    res = '0;
    if (last) begin
      opnd_left = '0;
      res.kind = KIND_TRUNCATED;
      return 1'b1;
    end
    opnd_left = n;
    held_kind = k;
    return 1'b0;
  endfunction

  function automatic logic decode_byte(in_t it, output out_t res);
    logic [7:0] b;
    logic       last;
    b = it.byte_in;
    last = it.is_last;
    res = '0;
    if (opnd_left != 2'd0) begin
      if (opnd_left == 2'd3)
        gn_delta = b;
      else if (opnd_left == 2'd2 && held_kind == KIND_ENV_SET)
        env_lo = b;
      opnd_left = opnd_left - 2'd1;
      if (opnd_left == 2'd0) begin
        res.kind = held_kind;
        case (held_kind)
          KIND_ENV_SET: begin
            res.amount = {4'd0, env_shape};
            res.env_period = {b, env_lo};
          end
          KIND_TEMPO: res.amount = b;
          KIND_GLIDE, KIND_NOISE_ADD: res.delta = b;
          KIND_GLIDE_NOTE: res.delta = gn_delta;
          default: ;
        endcase
        return 1'b1;
      end
      if (last) begin
        opnd_left = '0;
        res.kind = KIND_TRUNCATED;
        return 1'b1;
      end
      return 1'b0;
    end
    if (b >= SAMPLE_FIRST) begin
      res.kind = KIND_SAMPLE;
      res.amount = b - SILENCE_CODE;
    end else if (b == SILENCE_CODE) begin
      res.kind = KIND_SILENCE;
      res.row_done = 1'b1;
    end else if (b >= NOTE_FIRST) begin
      res.kind = KIND_NOTE;
      res.amount = b - NOTE_FIRST;
      res.row_done = 1'b1;
    end else if (b == ENV_OFF_CODE) begin
      res.kind = KIND_ENV_OFF;
    end else if (b >= ENV_SET_FIRST) begin
      env_shape = 4'(b - ROW_END_CODE);
      return hold_cmd(KIND_ENV_SET, 2'd2, last, res);
    end else if (b == ROW_END_CODE) begin
      res.kind = KIND_ROW_END;
      res.row_done = 1'b1;
    end else if (b >= ORN_FIRST) begin
      res.kind = KIND_ORNAMENT;
      res.amount = b - ORN_FIRST;
    end else if (b >= PERIOD_FIRST) begin
      res.kind = KIND_PERIOD;
      res.amount = b - PERIOD_FIRST;
    end else if (b >= VOLUME_FIRST) begin
      res.kind = KIND_VOLUME;
      res.amount = b - VOLUME_FIRST;
    end else if (b == TEMPO_CODE) begin
      return hold_cmd(KIND_TEMPO, 2'd1, last, res);
    end else if (b == GLIDE_CODE) begin
      return hold_cmd(KIND_GLIDE, 2'd1, last, res);
    end else if (b == GNOTE_CODE) begin
      return hold_cmd(KIND_GLIDE_NOTE, 2'd3, last, res);
    end else if (b == GLIDE_OFF_CODE) begin
      res.kind = KIND_GLIDE_OFF;
    end else begin
      return hold_cmd(KIND_NOISE_ADD, 2'd1, last, res);
    end
    return 1'b1;
  endfunction

  function automatic int next_pause();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic rand_last();
    return $urandom_range(0, 39) == 0;
  endfunction

  task automatic push_item(logic [7:0] b, logic last);
    in_t it;
    it.byte_in = b;
    it.is_last = last;
    byte_queue = {byte_queue, it};
  endtask

  task automatic add_random_command();
    logic [7:0] op;
    int         n_ops;
    n_ops = 0;
    case ($urandom_range(0, 13))
      0: op = 8'($urandom_range(SAMPLE_FIRST, 8'hFF));
      1: op = SILENCE_CODE;
      2: op = 8'($urandom_range(NOTE_FIRST, NOTE_LAST));
      3: op = ENV_OFF_CODE;
      4: begin
        op = 8'($urandom_range(ENV_SET_FIRST, ENV_SET_LAST));
        n_ops = 2;
      end
      5: op = ROW_END_CODE;
      6: op = 8'($urandom_range(ORN_FIRST, ROW_END_CODE - 1));
      7: op = 8'($urandom_range(PERIOD_FIRST, ORN_FIRST - 1));
      8: op = 8'($urandom_range(VOLUME_FIRST, PERIOD_FIRST - 1));
      9: begin
        op = TEMPO_CODE;
        n_ops = 1;
      end
      10: begin
        op = GLIDE_CODE;
        n_ops = 1;
      end
      11: begin
        op = GNOTE_CODE;
        n_ops = 3;
      end
      12: op = GLIDE_OFF_CODE;
      default: begin
        op = 8'($urandom_range(0, GLIDE_OFF_CODE - 1));
        n_ops = 1;
      end
    endcase
    push_item(op, rand_last());
    repeat (n_ops) push_item(8'($urandom_range(0, 255)), rand_last());
  endtask

  task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errors++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        in_data <= byte_queue.pop_front();
        in_valid <= 1'b1;
        in_gap = next_pause();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = next_pause();
    end
  end

  // monitor and prediction
  always @(posedge clk) begin
    out_t want;
    out_t res;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          $error("unexpected transaction of kind %0d", out_data.kind);
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_data.kind));
          check_field("amount", 16'(want.amount), 16'(out_data.amount));
          check_field("delta", 16'(want.delta), 16'(out_data.delta));
          check_field("env_period", want.env_period, out_data.env_period);
          check_field("row_done", 16'(want.row_done), 16'(out_data.row_done));
        end
      end
      if (in_valid && !in_stall) begin
        if (decode_byte(in_data, res))
          expected_cmds = {expected_cmds, res};
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if ($urandom_range(0, 199) == 0)
      quiet <= !quiet;
    if (cycles > CYCLE_LIMIT) begin
      $display("tracker_pattern_byte_decoder_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int n_directed;
    push_item(SAMPLE_FIRST, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(SILENCE_CODE, 1'b0);
    push_item(NOTE_FIRST, 1'b0);
    push_item(NOTE_LAST, 1'b0);
    push_item(ENV_OFF_CODE, 1'b0);
    push_item(ENV_SET_FIRST, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(ENV_SET_LAST, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(ROW_END_CODE, 1'b1);
    push_item(ORN_FIRST, 1'b0);
    push_item(PERIOD_FIRST, 1'b0);
    push_item(VOLUME_FIRST, 1'b0);
    push_item(TEMPO_CODE, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(GLIDE_CODE, 1'b0);
    push_item(8'h7F, 1'b1);
    push_item(GNOTE_CODE, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(GLIDE_OFF_CODE, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    // stream ends inside a command
    push_item(TEMPO_CODE, 1'b1);
    push_item(GNOTE_CODE, 1'b0);
    push_item(8'h01, 1'b1);
    n_directed = byte_queue.size();
    while (byte_queue.size() < n_directed + RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0)
        push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else
        add_random_command();
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (byte_queue.size() > 0 || in_valid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tracker_pattern_byte_decoder_unit regression: pass");
    else
      $display("tracker_pattern_byte_decoder_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
